### rtl/clbp_pkg.sv
// Shared types and constants of the circular LBP block: configuration
// register codes, channel payloads and the result tag that rides the pipeline.
// No dependencies.
package clbp_pkg;

	// Configuration register widths and port sizes
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 12;
	localparam int RADIUS_REG_W = 3;
	localparam int OFFSET_REG_W = 8;
	localparam int CFG_DATA_W   = 12;
	localparam int CFG_INDEX_W  = 2;

	// Register indexes of the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH      = 2'd0,
		REG_IMAGE_HEIGHT     = 2'd1,
		REG_CIRCLE_RADIUS    = 2'd2,
		REG_THRESHOLD_OFFSET = 2'd3
	} cfg_reg_t;

	// Input request payload
	typedef struct packed {
		logic [7:0] pixel_value;
	} pix_req_t;

	// Output request payload
	typedef struct packed {
		logic [7:0]  pattern_code;
		logic [9:0]  center_column;
		logic [11:0] center_row;
		logic        frame_last;
	} code_req_t;

	// Tag that travels beside a pixel down the pipeline
	typedef struct packed {
		logic        emit;
		logic        frame_last;
		logic [9:0]  center_column;
		logic [11:0] center_row;
	} res_meta_t;

endpackage

### rtl/clbp_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Used for both the pixel input and the code output; no dependencies.
interface clbp_stream_if #(
	parameter type T = logic [7:0]
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/circular_lbp_code.sv
// Circular LBP, 8 bilinear samples on a radius 1..MAX_RADIUS circle, 8-bit code.
// A taken pixel passes stage 1, the window, stage 3 and the output register.
// Throughput: one pixel per clock unless a code waits unread; the line-buffer
// RAM does one read and one write per pixel, and back-to-back pixels on one
// column use write forwarding. Reset (async, active low) clears counters and
// pipeline, sets the registers to 640/480/1/3; line RAM and window are not cleared.
module circular_lbp_code #(
	parameter int MAX_RADIUS = 4,
	parameter int MAX_WIDTH  = 1024,
	parameter int FRAC_BITS  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	clbp_stream_if.sink                       pixel,
	clbp_stream_if.source                     code,
	input  logic                              cfg_we,
	input  logic [clbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [clbp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import clbp_pkg::*;

	localparam int LS  = 2 * MAX_RADIUS;
	localparam int WIN = LS + 1;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int SLW = $clog2(LS);
	localparam int RW  = $clog2(MAX_RADIUS + 1);
	localparam int WB  = $clog2(MAX_WIDTH + 1);
	localparam int XW  = (WB > HEIGHT_REG_W ? WB : HEIGHT_REG_W) + 1;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [RADIUS_REG_W-1:0] radius_q;
	logic [OFFSET_REG_W-1:0] offset_q;

	logic [CW-1:0]           col_q;
	logic [HEIGHT_REG_W-1:0] row_q;
	logic [SLW-1:0]          slot_q;

	logic [XW-1:0] w_eff, h_eff, r_x, col_x, row_x, cc_x, cr_x;
	logic [RW-1:0] r_eff;
	logic          interior, last, col_wrap, row_wrap;
	logic          adv, take;
	pix_req_t      pix_req;
	res_meta_t     meta_s1, meta_s3;
	logic          lb_valid_s1;
	logic [7:0]    newcol [WIN];
	logic [7:0]    pattern;
	logic          out_valid_q;
	code_req_t     out_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_W'(640);
			height_q <= HEIGHT_REG_W'(480);
			radius_q <= RADIUS_REG_W'(1);
			offset_q <= OFFSET_REG_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:      width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT:     height_q <= cfg_data[HEIGHT_REG_W-1:0];
				REG_CIRCLE_RADIUS:    radius_q <= cfg_data[RADIUS_REG_W-1:0];
				REG_THRESHOLD_OFFSET: offset_q <= cfg_data[OFFSET_REG_W-1:0];
			endcase
		end
	end

	// Clamp the registers to usable values
	always_comb begin
		w_eff = XW'(width_q);
		if (width_q == '0) begin
			w_eff = XW'(1);
		end else if (XW'(width_q) > XW'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end
		h_eff = XW'(height_q);
		if (height_q == '0) begin
			h_eff = XW'(1);
		end
		r_x = XW'(radius_q);
		if (radius_q == '0) begin
			r_x = XW'(1);
		end else if (XW'(radius_q) > XW'(MAX_RADIUS)) begin
			r_x = XW'(MAX_RADIUS);
		end
	end

	assign r_eff = r_x[RW-1:0];

	// Position of the incoming pixel and of its center
	assign col_x    = XW'(col_q);
	assign row_x    = XW'(row_q);
	assign interior = (col_x >= (r_x << 1)) && (row_x >= (r_x << 1))
		&& (col_x < w_eff) && (row_x < h_eff);
	assign last     = (col_x == w_eff - XW'(1)) && (row_x == h_eff - XW'(1));
	assign col_wrap = (col_x + XW'(1)) >= w_eff;
	assign row_wrap = (row_x + XW'(1)) >= h_eff;
	assign cc_x     = col_x - r_x;
	assign cr_x     = row_x - r_x;

	// Handshake: the whole pipeline moves unless a result waits unread
	assign adv         = !out_valid_q || code.ready;
	assign pixel.ready = adv;
	assign take        = pixel.valid && adv;
	assign pix_req     = pixel.data;

	// Frame counters; slot tracks row modulo the line count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (take) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + 1'b1;
					slot_q <= (slot_q == SLW'(LS - 1)) ? '0 : slot_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Result tag for the pixel entering stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (adv) begin
			meta_s1.emit          <= take && interior;
			meta_s1.frame_last    <= last;
			meta_s1.center_column <= cc_x[9:0];
			meta_s1.center_row    <= cr_x[HEIGHT_REG_W-1:0];
		end
	end

	clbp_line_buf #(
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.take     (take),
		.col      (col_q),
		.slot     (slot_q),
		.pix      (pix_req.pixel_value),
		.valid_s1 (lb_valid_s1),
		.newcol   (newcol)
	);

	clbp_sampler #(
		.MAX_RADIUS (MAX_RADIUS),
		.FRAC_BITS  (FRAC_BITS)
	) u_sampler (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.shift_en (adv && lb_valid_s1),
		.newcol   (newcol),
		.r_eff    (r_eff),
		.offset   (offset_q),
		.meta_s1  (meta_s1),
		.meta_s3  (meta_s3),
		.pattern  (pattern)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= meta_s3.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && meta_s3.emit) begin
			out_data_q <= '{
				pattern_code:  pattern,
				center_column: meta_s3.center_column,
				center_row:    meta_s3.center_row,
				frame_last:    meta_s3.frame_last
			};
		end
	end

	assign code.valid = out_valid_q;
	assign code.data  = out_data_q;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < (SLW+1)'(LS))
		else $error("line slot counter out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(col_q) < XW'(MAX_WIDTH))
		else $error("column counter beyond line buffer depth");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		take && col_wrap && row_wrap |=> col_q == '0 && row_q == '0 && slot_q == '0)
		else $error("counters did not return to frame start");
endmodule

### rtl/clbp_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Read during write to the same address returns the old data. No dependencies.
module clbp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/clbp_line_buf.sv
// Line buffers: one RAM word per column holds that column's pixels of the
// last 2*MAX_RADIUS rows. Read-modify-write per pixel with write forwarding.
// Depends on clbp_ram.
module clbp_line_buf #(
	parameter int MAX_RADIUS = 4,
	parameter int MAX_WIDTH  = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            take,
	input  logic [$clog2(MAX_WIDTH)-1:0]    col,
	input  logic [$clog2(2*MAX_RADIUS)-1:0] slot,
	input  logic [7:0]                      pix,
	output logic                            valid_s1,
	output logic [7:0]                      newcol [2*MAX_RADIUS+1]
);
	localparam int LS  = 2 * MAX_RADIUS;
	localparam int WW  = 8 * LS;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int SLW = $clog2(LS);

	logic [CW-1:0]  col_s1;
	logic [SLW-1:0] slot_s1;
	logic [7:0]     pix_s1;
	logic           fwd_s1;
	logic [WW-1:0]  fwd_word_s1;
	logic [WW-1:0]  rdata;
	logic [WW-1:0]  word_s1;
	logic [WW-1:0]  merged;
	logic           we;

	// Write back happens as the item leaves stage 1
	assign we = adv && valid_s1;

	clbp_ram #(
		.WIDTH (WW),
		.DEPTH (MAX_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (col_s1),
		.wdata (merged),
		.re    (take),
		.raddr (col),
		.rdata (rdata)
	);

	// Forwarded word wins when the previous pixel wrote this column
	assign word_s1 = fwd_s1 ? fwd_word_s1 : rdata;

	// Replace the current row's lane with the new pixel
	always_comb begin
		merged = word_s1;
		for (int j = 0; j < LS; j++) begin
			if (slot_s1 == SLW'(j)) begin
				merged[8*j +: 8] = pix_s1;
			end
		end
	end

	// Column for the window, oldest row first; lane order rotates with the row
	always_comb begin
		logic [SLW:0] idx;
		for (int k = 0; k < LS; k++) begin
			idx = {1'b0, slot_s1} + (SLW+1)'(k);
			if (idx >= (SLW+1)'(LS)) begin
				idx = idx - (SLW+1)'(LS);
			end
			newcol[k] = word_s1[{idx[SLW-1:0], 3'b000} +: 8];
		end
		newcol[LS] = pix_s1;
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take;
			fwd_s1   <= take && valid_s1 && (col == col_s1);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			col_s1      <= col;
			slot_s1     <= slot;
			pix_s1      <= pix;
			fwd_word_s1 <= merged;
		end
	end

	a_take_adv: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> adv)
		else $error("pixel taken while pipeline stalled");

	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forwarding flagged without a pixel in stage 1");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(col_s1) && $stable(slot_s1))
		else $error("stage 1 changed during stall");
endmodule

### rtl/clbp_sampler.sv
// Window registers, bilinear sampling of 8 circle points and the signed
// threshold compare that forms the pattern code. Weights and tap positions
// per radius are elaboration-time tables. Depends on clbp_pkg.
module clbp_sampler #(
	parameter int MAX_RADIUS = 4,
	parameter int FRAC_BITS  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              shift_en,
	input  logic [7:0]                        newcol [2*MAX_RADIUS+1],
	input  logic [$clog2(MAX_RADIUS+1)-1:0]   r_eff,
	input  logic [7:0]                        offset,
	input  clbp_pkg::res_meta_t               meta_s1,
	output clbp_pkg::res_meta_t               meta_s3,
	output logic [7:0]                        pattern
);
	import clbp_pkg::*;

	localparam int LS  = 2 * MAX_RADIUS;
	localparam int WIN = LS + 1;
	localparam int IW  = $clog2(WIN);
	localparam int ONE = 1 << FRAC_BITS;
	localparam int WTW = 2 * FRAC_BITS + 1;
	localparam int PW  = WTW + 8;
	localparam int SW  = PW + 2;
	localparam int INV_SQRT2_Q24 = 11863283;
	localparam int DIR_X [8] = '{2, 1, 0, -1, -2, -1, 0, 1};
	localparam int DIR_Y [8] = '{0, 1, 2, 1, 0, -1, -2, -1};

	// Fixed-point offset along one axis: full radius, diagonal or none
	function automatic int axis_off(input int kind, input int rad, input int dg);
		int off;
		unique case (kind)
			2:       off = rad * ONE;
			1:       off = dg;
			-1:      off = -dg;
			-2:      off = -rad * ONE;
			default: off = 0;
		endcase
		return off;
	endfunction

	logic [IW-1:0]  tx_tbl [1:MAX_RADIUS][8][2];
	logic [IW-1:0]  ty_tbl [1:MAX_RADIUS][8][2];
	logic [WTW-1:0] wt_tbl [1:MAX_RADIUS][8][4];

	// Tap positions and corner weights for every radius and sample
	for (genvar gr = 1; gr <= MAX_RADIUS; gr++) begin : g_rad
		localparam int Diag = (gr * INV_SQRT2_Q24 + (1 << (23 - FRAC_BITS)))
			>> (24 - FRAC_BITS);
		localparam int Ctr = (LS - gr) * ONE;
		for (genvar gt = 0; gt < 8; gt++) begin : g_smp
			localparam int PosX = Ctr + axis_off(DIR_X[gt], gr, Diag);
			localparam int PosY = Ctr + axis_off(DIR_Y[gt], gr, Diag);
			localparam int FrX  = PosX % ONE;
			localparam int FrY  = PosY % ONE;
			localparam int X0   = PosX / ONE;
			localparam int Y0   = PosY / ONE;
			localparam int X1   = (FrX != 0) ? X0 + 1 : X0;
			localparam int Y1   = (FrY != 0) ? Y0 + 1 : Y0;
			assign tx_tbl[gr][gt][0] = IW'(X0);
			assign tx_tbl[gr][gt][1] = IW'(X1);
			assign ty_tbl[gr][gt][0] = IW'(Y0);
			assign ty_tbl[gr][gt][1] = IW'(Y1);
			assign wt_tbl[gr][gt][0] = WTW'((ONE - FrX) * (ONE - FrY));
			assign wt_tbl[gr][gt][1] = WTW'(FrX * (ONE - FrY));
			assign wt_tbl[gr][gt][2] = WTW'((ONE - FrX) * FrY);
			assign wt_tbl[gr][gt][3] = WTW'(FrX * FrY);
		end
	end

	logic [7:0]    win_q [WIN][WIN];
	logic [PW-1:0] prod_c  [8][4];
	logic [PW-1:0] prod_s3 [8][4];
	logic [7:0]    center_s3;
	logic [IW-1:0] ctr_idx;
	res_meta_t     meta_s2;

	// Window shifts west by one column per pixel
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int k = 0; k < WIN; k++) begin
				for (int j = 0; j < WIN - 1; j++) begin
					win_q[k][j] <= win_q[k][j+1];
				end
				win_q[k][WIN-1] <= newcol[k];
			end
		end
	end

	assign ctr_idx = IW'(LS) - IW'(r_eff);

	// Stage 2: pick the four corners of each sample and weight them
	always_comb begin
		for (int t = 0; t < 8; t++) begin
			for (int c = 0; c < 4; c++) begin
				prod_c[t][c] = PW'(wt_tbl[r_eff][t][c])
					* PW'(win_q[ty_tbl[r_eff][t][c/2]][tx_tbl[r_eff][t][c%2]]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3   <= prod_c;
			center_s3 <= win_q[ctr_idx][ctr_idx];
		end
	end

	// Tag follows the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
			meta_s3 <= '0;
		end else if (adv) begin
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
		end
	end

	// Stage 3: floor the weighted sums and compare against center - offset
	always_comb begin
		logic [SW-1:0]     sum;
		logic [7:0]        samp;
		logic signed [9:0] limit;
		limit = $signed({2'b00, center_s3}) - $signed({2'b00, offset});
		for (int t = 0; t < 8; t++) begin
			sum = SW'(prod_s3[t][0]) + SW'(prod_s3[t][1])
				+ SW'(prod_s3[t][2]) + SW'(prod_s3[t][3]);
			samp = sum[2*FRAC_BITS +: 8];
			pattern[7-t] = $signed({2'b00, samp}) > limit;
		end
	end

	a_shift_adv: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en |-> adv)
		else $error("window shifted while pipeline stalled");

	a_tag_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> meta_s3 == $past(meta_s2))
		else $error("result tag lost between stages 2 and 3");

	a_tag_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(meta_s2) && $stable(meta_s3))
		else $error("result tag moved during stall");
endmodule

### sim/tb_circular_lbp_code.sv
// Testbench of circular_lbp_code: streams pixel frames under changing register
// settings and checks every code request against a local bit-accurate predictor
// or a directed expected code. Depends on clbp_pkg, clbp_stream_if and circular_lbp_code.
module tb_circular_lbp_code;
	import clbp_pkg::*;

	localparam int MAX_R       = 4;
	localparam int MAX_W       = 1024;
	localparam int FRAC        = 8;
	localparam int ONE         = 1 << FRAC;
	localparam int WIN         = 2 * MAX_R + 1;
	localparam int LINES       = 2 * MAX_R;
	localparam int INV_SQRT2   = 11863283;     // 1/sqrt(2) in Q0.24
	localparam int SETTLE_CYC  = 8;            // pipeline depth plus margin
	localparam int HOLD_CYC    = 400;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_CAP   = 100;

	typedef enum logic {ROW_REG, ROW_PIX} row_kind_t;

	// One line of the directed stimulus: a register write or a pixel
	typedef struct packed {
		row_kind_t   kind;
		cfg_reg_t    reg_idx;
		logic [11:0] value;
		logic        typed;
		code_req_t   want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	clbp_stream_if #(.T(pix_req_t))  pix_if ();
	clbp_stream_if #(.T(code_req_t)) code_if ();

	circular_lbp_code DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pix_if),
		.code     (code_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predictor state: line store, window, raster position, registers
	logic [7:0]  line_mem [0:LINES*MAX_W-1];
	logic [7:0]  win_mem  [0:WIN-1][0:WIN-1];
	int          pos_col;
	int          pos_row;
	logic [10:0] img_width;
	logic [11:0] img_height;
	logic [2:0]  radius_reg;
	logic [7:0]  offset_reg;

	code_req_t   expected_codes [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned pixels_sent    = 0;
	int unsigned burst_left     = 0;
	bit          hold_req       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("tb_circular_lbp_code NOT OK");
		$finish;
	end

	// x step of sample t: 2 full radius, 1 diagonal, 0 none; y step is t + 6
	function automatic int ring_dir(input int t);
		case (t % 8)
			0:       return 2;
			1, 7:    return 1;
			2, 6:    return 0;
			3, 5:    return -1;
			default: return -2;
		endcase
	endfunction

	function automatic int dir_offset(input int kind, input int r, input int diag);
		case (kind)
			2:       return r << FRAC;
			1:       return diag;
			-1:      return -diag;
			-2:      return -(r << FRAC);
			default: return 0;
		endcase
	endfunction

	// Bilinear value of sample t around the window center, floored
	function automatic int ring_sample(input int r, input int diag, input int t);
		int vx, vy, cx, cy, cx1, cy1, a, b, ctr, acc;
		ctr = LINES - r;
		vx  = dir_offset(ring_dir(t), r, diag) + (r << FRAC);
		vy  = dir_offset(ring_dir(t + 6), r, diag) + (r << FRAC);
		cx  = ctr + (vx >> FRAC) - r;
		cy  = ctr + (vy >> FRAC) - r;
		a   = vx & (ONE - 1);
		b   = vy & (ONE - 1);
		cx1 = (cx + (a != 0 ? 1 : 0)) % WIN;
		cy1 = (cy + (b != 0 ? 1 : 0)) % WIN;
		acc = (ONE - a) * (ONE - b) * int'(win_mem[cy][cx])
			+ a * (ONE - b) * int'(win_mem[cy][cx1])
			+ (ONE - a) * b * int'(win_mem[cy1][cx])
			+ a * b * int'(win_mem[cy1][cx1]);
		return acc >> (2 * FRAC);
	endfunction

	// Advances the predictor by one pixel; returns 1 when a code is due
	function automatic bit code_for_pixel(input logic [7:0] pix, output code_req_t res);
		int         w, h, r, c, rw, ctr, diag, limit, k, j, t;
		logic [7:0] colv [0:WIN-1];
		bit         hit;
		w  = (img_width == 0) ? 1 : (img_width > MAX_W) ? MAX_W : int'(img_width);
		h  = (img_height == 0) ? 1 : int'(img_height);
		r  = (radius_reg == 0) ? 1 : (radius_reg > MAX_R) ? MAX_R : int'(radius_reg);
		c  = pos_col % MAX_W;
		rw = pos_row;
		res = '0;
		// column above the pixel leaves the line store before its slot is overwritten
		for (k = 0; k < LINES; k++)
			colv[k] = line_mem[((rw + k) % LINES) * MAX_W + c];
		colv[LINES] = pix;
		for (k = 0; k < WIN; k++) begin
			for (j = 0; j < WIN - 1; j++)
				win_mem[k][j] = win_mem[k][j + 1];
			win_mem[k][WIN - 1] = colv[k];
		end
		line_mem[(rw % LINES) * MAX_W + c] = pix;
		// only centers at least r away from every edge give a code
		hit = c >= 2 * r && rw >= 2 * r && c < w && rw < h;
		if (hit) begin
			diag  = (r * INV_SQRT2 + (1 << (23 - FRAC))) >> (24 - FRAC);
			ctr   = LINES - r;
			limit = int'(win_mem[ctr][ctr]) - int'(offset_reg);
			for (t = 0; t < 8; t++)
				if (ring_sample(r, diag, t) > limit)
					res.pattern_code[7 - t] = 1'b1;
			res.center_column = 10'(c - r);
			res.center_row    = 12'(rw - r);
			res.frame_last    = (c == w - 1) && (rw == h - 1);
		end
		// raster position of the next pixel
		if (c + 1 >= w) begin
			pos_col = 0;
			pos_row = (rw + 1 >= h) ? 0 : rw + 1;
		end else begin
			pos_col = c + 1;
		end
		return hit;
	endfunction

	function automatic logic [7:0] pick_pixel(input int style, input int base);
		int v;
		case (style)
			0:       v = int'($urandom_range(0, 255));
			1:       v = base + int'($urandom_range(0, 8)) - 4;
			default: v = $urandom_range(0, 1) ? 255 : 0;
		endcase
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:   img_width  = 11'(value);
			REG_IMAGE_HEIGHT:  img_height = 12'(value);
			REG_CIRCLE_RADIUS: radius_reg = 3'(value);
			default:           offset_reg = 8'(value);
		endcase
	endtask

	// Stop offering pixels and wait until every code has drained
	task automatic settle();
		@(negedge clk);
		pix_if.valid <= 1'b0;
		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Offer one pixel request in bursts with random gaps, then predict its code
	task automatic feed_pixel(input logic [7:0] value, input bit typed, input code_req_t want);
		int        gap;
		bit        hit;
		code_req_t predicted;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		repeat (gap) begin
			@(negedge clk);
			pix_if.valid <= 1'b0;
		end
		@(negedge clk);
		pix_if.valid            <= 1'b1;
		pix_if.data.pixel_value <= value;
		do @(posedge clk); while (!pix_if.ready);
		burst_left--;
		pixels_sent++;
		hit = code_for_pixel(value, predicted);
		if (typed)
			expected_codes = {expected_codes, want};
		else if (hit)
			expected_codes = {expected_codes, predicted};
	endtask

	// One full frame; optionally the offset changes halfway through
	task automatic run_frame(input int w, input int h, input int r, input int ofs,
			input bit split_ofs);
		int n, style, base, split, i;
		n     = ((w == 0) ? 1 : (w > MAX_W) ? MAX_W : w) * ((h == 0) ? 1 : h);
		style = $urandom_range(0, 2);
		base  = $urandom_range(0, 255);
		split = split_ofs ? n / 2 : n;
		settle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_CIRCLE_RADIUS, r);
		write_reg(REG_THRESHOLD_OFFSET, ofs);
		for (i = 0; i < n; i++) begin
			if (i == split) begin
				settle();
				write_reg(REG_THRESHOLD_OFFSET, $urandom_range(0, 255));
			end
			feed_pixel(pick_pixel(style, base), 1'b0, '0);
		end
	endtask

	// Code receiver: segments of steady, random and patterned stalls, plus long holds
	initial begin : drain_codes
		int seg_left;
		int seg_mode;
		int hold_left;
		int tick;
		bit rdy;
		seg_left      = 0;
		seg_mode      = 0;
		hold_left     = 0;
		tick          = 0;
		code_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req && pix_if.valid) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYC;
			end
			if (seg_left == 0) begin
				seg_mode = $urandom_range(0, 3);
				seg_left = $urandom_range(16, 160);
			end
			seg_left--;
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (seg_mode)
					0:       rdy = 1'b1;
					1:       rdy = ($urandom_range(0, 3) != 0);
					2:       rdy = $urandom_range(0, 1);
					default: rdy = (tick % 5) < 3;
				endcase
			end
			code_if.ready <= rdy;
		end
	end

	// Compare each accepted code request with the oldest prediction
	always @(posedge clk) begin : check_codes
		code_req_t seen;
		code_req_t want;
		if (arst_n && code_if.valid && code_if.ready) begin
			seen = code_if.data;
			if (expected_codes.size() == 0) begin
				report_mismatch("unexpected code, pattern_code", seen.pattern_code, 0);
			end else begin
				want = expected_codes.pop_front();
				if (seen.pattern_code != want.pattern_code)
					report_mismatch("pattern_code", seen.pattern_code, want.pattern_code);
				if (seen.center_column != want.center_column)
					report_mismatch("center_column", seen.center_column, want.center_column);
				if (seen.center_row != want.center_row)
					report_mismatch("center_row", seen.center_row, want.center_row);
				if (seen.frame_last != want.frame_last)
					report_mismatch("frame_last", seen.frame_last, want.frame_last);
			end
		end
	end

	initial begin : run
		stim_row_t   directed_rows [$];
		int          rr, rreg, w, h, k;
		int unsigned start_pixels;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_IMAGE_WIDTH;
		cfg_data     = '0;
		pix_if.valid = 1'b0;
		pix_if.data  = '0;
		pos_col      = 0;
		pos_row      = 0;
		img_width    = 11'd640;
		img_height   = 12'd480;
		radius_reg   = 3'd1;
		offset_reg   = 8'd3;
		for (k = 0; k < LINES * MAX_W; k++)
			line_mem[k] = '0;
		for (k = 0; k < WIN * WIN; k++)
			win_mem[k / WIN][k % WIN] = '0;

		// 3x3 frames: one interior pixel each; flat white, flat black, then mixed
		directed_rows = '{
			'{ROW_REG, REG_IMAGE_WIDTH,      12'd3,   1'b0, '0},
			'{ROW_REG, REG_IMAGE_HEIGHT,     12'd3,   1'b0, '0},
			'{ROW_REG, REG_CIRCLE_RADIUS,    12'd1,   1'b0, '0},
			'{ROW_REG, REG_THRESHOLD_OFFSET, 12'd3,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd255, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd255, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd255, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd255, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd255, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd255, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd255, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd255, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd255, 1'b1, '{8'hFF, 10'd1, 12'd1, 1'b1}},
			// zero offset: equal samples do not set a bit
			'{ROW_REG, REG_THRESHOLD_OFFSET, 12'd0,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd0,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd0,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd0,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd0,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd0,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd0,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd0,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd0,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd0,   1'b1, '{8'h00, 10'd1, 12'd1, 1'b1}},
			// radius 0 is taken as 1
			'{ROW_REG, REG_CIRCLE_RADIUS,    12'd0,   1'b0, '0},
			'{ROW_REG, REG_THRESHOLD_OFFSET, 12'd2,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd0,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd255, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd7,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd128, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd128, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd129, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd254, 1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd1,   1'b0, '0},
			'{ROW_PIX, REG_IMAGE_WIDTH,      12'd126, 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				settle();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
			end else begin
				feed_pixel(directed_rows[i].value[7:0], directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		// random small frames; some too small, some with radius out of range
		start_pixels = pixels_sent;
		while (pixels_sent - start_pixels < 220) begin
			rr   = $urandom_range(1, MAX_R);
			w    = $urandom_range(2 * rr + 1, 2 * rr + 12);
			h    = $urandom_range(2 * rr + 1, 2 * rr + 6);
			rreg = rr;
			case ($urandom_range(0, 7))
				0:       rreg = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_R + 1, 7);
				1:       w = $urandom_range(0, 2 * rr);
				2:       h = $urandom_range(0, 2 * rr);
				default: ;
			endcase
			if ($urandom_range(0, 7) == 0)
				hold_req = 1'b1;
			run_frame(w, h, rreg,
				$urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 255),
				$urandom_range(0, 2) == 0);
		end

		// receiver holds off for a long stretch while a busy frame streams in
		hold_req = 1'b1;
		run_frame(12, 8, 1, $urandom_range(0, 255), 1'b0);

		// register extremes: zero sizes, radius above range and largest radius
		run_frame(0, 5, 1, 3, 1'b0);
		run_frame(5, 0, 1, 3, 1'b0);
		run_frame(9, 9, 7, 255, 1'b0);
		run_frame(9, 9, 4, 0, 1'b0);

		settle();
		if (mismatch_count == 0)
			$display("tb_circular_lbp_code OK");
		else
			$display("tb_circular_lbp_code NOT OK");
		$finish;
	end

endmodule
